@@ sv/lprd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types and constants for the length-prefixed request deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

  // Header and length fields are 32-bit little-endian words
  localparam int unsigned FieldBytes = 4;
  localparam int unsigned FieldIdxW  = $clog2(FieldBytes);

  // Reset value of the maximum argument count register
  localparam logic [31:0] MaxArgsReset = 32'd1024;

  // Status codes reported on the final byte of a request
  localparam logic [1:0] StatusNone      = 2'd0;
  localparam logic [1:0] StatusAccepted  = 2'd1;
  localparam logic [1:0] StatusMalformed = 2'd2;

  // One request byte
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last;
  } lprd_in_t;

  // One result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       arg_begin;
    logic       arg_end;
    logic [1:0] status;
  } lprd_out_t;

endpackage : lprd_pkg
`default_nettype wire

@@ sv/lprd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lprd_core
// Frame parser: holds the parse state and turns one request byte into one
// result item in a single combinational pass. State advances on fire_i.
// ----------------------------------------------------------------------------
module lprd_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      fire_i,
  input  wire lprd_pkg::lprd_in_t  item_i,
  input  wire  [31:0]              max_args_i,
  output lprd_pkg::lprd_out_t      result_o
);
  import lprd_pkg::*;

  typedef enum logic [2:0] {
    PhCount,
    PhLen,
    PhPayFirst,
    PhPay,
    PhDone
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [FieldIdxW-1:0] idx_q, idx_d;
  logic [31:0]          acc_q, acc_d;
  logic [31:0]          args_q, args_d;
  logic [31:0]          pay_q, pay_d;
  logic                 err_q, err_d;

  logic [31:0]          field_val;
  logic                 field_done;
  logic [31:0]          args_dec;
  lprd_out_t            res;

  // Accumulator with the current byte dropped into its lane
  always_comb begin
    field_val = acc_q;
    field_val[{idx_q, 3'b000} +: 8] = item_i.byte_in;
  end

  assign field_done = (idx_q == FieldIdxW'(FieldBytes - 1));
  assign args_dec   = args_q - 32'd1;

  // Next state and result for the item at the input register
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    args_d  = args_q;
    pay_d   = pay_q;
    err_d   = err_q;
    res     = '0;

    if (!err_q) begin
      unique case (phase_q)
        PhCount: begin
          acc_d = field_val;
          idx_d = idx_q + 1'b1;
          if (field_done) begin
            acc_d = '0;
            if (field_val > max_args_i) begin
              err_d = 1'b1;
            end else begin
              args_d  = field_val;
              phase_d = (field_val == '0) ? PhDone : PhLen;
            end
          end
        end
        PhLen: begin
          acc_d = field_val;
          idx_d = idx_q + 1'b1;
          if (field_done) begin
            acc_d  = '0;
            args_d = args_dec;
            if (field_val == '0) begin
              // empty argument: marks only
              res.arg_begin = 1'b1;
              res.arg_end   = 1'b1;
              phase_d       = (args_dec == '0) ? PhDone : PhLen;
            end else begin
              pay_d   = field_val;
              phase_d = PhPayFirst;
            end
          end
        end
        PhPayFirst, PhPay: begin
          res.data_byte  = item_i.byte_in;
          res.data_valid = 1'b1;
          res.arg_begin  = (phase_q == PhPayFirst);
          phase_d        = PhPay;
          if (pay_q <= 32'd1) begin
            res.arg_end = 1'b1;
            pay_d       = '0;
            phase_d     = (args_q == '0) ? PhDone : PhLen;
          end else begin
            pay_d = pay_q - 32'd1;
          end
        end
        PhDone: begin
          // trailing byte after the last argument
          err_d = 1'b1;
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end

    // End of buffer: report and start over
    if (item_i.last) begin
      res.status = (!err_d && phase_d == PhDone) ? StatusAccepted : StatusMalformed;
      phase_d    = PhCount;
      idx_d      = '0;
      acc_d      = '0;
      args_d     = '0;
      pay_d      = '0;
      err_d      = 1'b0;
    end
  end

  assign result_o = res;

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCount;
      idx_q   <= '0;
      acc_q   <= '0;
      args_q  <= '0;
      pay_q   <= '0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      args_q  <= args_d;
      pay_q   <= pay_d;
      err_q   <= err_d;
    end
  end

  // Status only on the final byte
  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last |-> res.status == StatusNone)
    else $error("status reported on a non-final byte");

  // Final byte leaves a clean frame
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last |=> phase_q == PhCount && !err_q && idx_q == '0)
    else $error("frame state not cleared after final byte");

  // Nothing passes once an error is held
  a_quiet_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && err_q |-> !res.data_valid && !res.arg_begin && !res.arg_end)
    else $error("output produced after error");

  // Payload phases always have bytes left
  a_pay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPay || phase_q == PhPayFirst) |-> pay_q != '0)
    else $error("payload phase with zero bytes remaining");

endmodule : lprd_core
`default_nettype wire

@@ sv/length_prefixed_request_deframer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_unit
// Byte-stream request deframer with input register, parser and result
// register.
// ----------------------------------------------------------------------------
// Takes one request byte per cycle and returns one result item per byte.
// A byte lands in the input register, the parser updates its counters in
// one pass and the result register holds the item
// until it is taken. A new byte is accepted each cycle while the result side
// keeps draining; a stall on the output holds the result register and then
// the input register, so at most two items are in flight. max_args is
// written through the cfg channel, which is always ready; write it only
// between requests while no item is in flight.
module length_prefixed_request_deframer_unit (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // request bytes
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire lprd_pkg::lprd_in_t  in_item_i,
  // result items
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output lprd_pkg::lprd_out_t      out_item_o,
  // max_args write
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire  [31:0]              cfg_data_i
);
  import lprd_pkg::*;

  lprd_in_t   in_q;
  logic       in_valid_q;
  lprd_out_t  out_q;
  logic       out_valid_q;
  logic [31:0] max_args_q;
  logic       advance;
  logic       in_take;
  lprd_out_t  result;

  // Handshake
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q <= MaxArgsReset;
    end else if (cfg_valid_i) begin
      max_args_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  // Parser
  lprd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .item_i     (in_q),
    .max_args_i (max_args_q),
    .result_o   (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("result item changed while stalled");

  // Stalled input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q && $stable(in_q))
    else $error("input register changed while stalled");

  // Input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled with room downstream");

endmodule : length_prefixed_request_deframer_unit
`default_nettype wire
